>>> hw/rtl/sxe_pkg.sv
package sxe_pkg;

    // Default depth of the request queue between the front end and the back end.
    localparam int unsigned Q_DEPTH = 4;

    // Configuration register reset values.
    localparam logic [7:0]  MATCH_RST = 8'd1;
    localparam logic [7:0]  TS_RST    = 8'd2;
    localparam logic [7:0]  TV_RST    = 8'd6;
    localparam logic [9:0]  DROP_RST  = 10'd12;
    localparam logic [15:0] MIN_RST   = 16'd16;

    // Register indexes on the configuration port (word address).
    localparam logic [2:0] REG_MATCH = 3'd0;
    localparam logic [2:0] REG_TS    = 3'd1;
    localparam logic [2:0] REG_TV    = 3'd2;
    localparam logic [2:0] REG_DROP  = 3'd3;
    localparam logic [2:0] REG_MIN   = 3'd4;

    // Action codes of an input request.
    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_RIGHT  = 3'd1;
    localparam logic [2:0] ACT_SEED   = 3'd2;
    localparam logic [2:0] ACT_LEFT   = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAIR,
        CMD_FINISH
    } t_kind;

    typedef enum logic [1:0] {
        PH_RIGHT,
        PH_SEED,
        PH_LEFT
    } t_phase;

    // Classified request as it travels through the queue.
    typedef struct packed {
        t_kind              kind;
        t_phase             phase;
        logic signed [9:0]  gain;
        logic               zero;
        logic [31:0]        gen_pos;
        logic [31:0]        est_pos;
        logic [7:0]         seed_len;
    } t_cmd;

    // Partial results of a finished hit, handed to the report stage.
    typedef struct packed {
        logic [40:0] sum_rs;
        logic [39:0] left_best;
        logic [31:0] gen_pos;
        logic [31:0] est_pos;
        logic [31:0] back_cnt;
        logic [31:0] fwd_cnt;
        logic [31:0] right_cnt;
    } t_snap;

endpackage

>>> hw/rtl/seed_xdrop_extension.sv
// A finish request's result passes from the queue through the report stage's snapshot
// register into the output register, where it is valid until the consumer takes it.
// Throughput: one request per cycle while the queue has room; the back end settles each
// base pair with a narrow deficit compare and a single 40-bit best-score update.
// Start, pair and unknown requests produce no result; a finish produces exactly one.
// Reset is synchronous and active low: it restores the default configuration, empties
// the queue and the report stages, and clears the hit state. No clearing pass follows.
module seed_xdrop_extension #(
    parameter int unsigned QUEUE_DEPTH = sxe_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_gen_base,
    input  logic [7:0]  i_est_base,
    input  logic [31:0] i_gen_position,
    input  logic [31:0] i_est_position,
    input  logic [7:0]  i_seed_len,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_keep,
    output logic [31:0] o_gen_start,
    output logic [31:0] o_est_start,
    output logic [31:0] o_seg_length,
    output logic [31:0] o_total_score,
    output logic [31:0] o_diag_extent,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sxe_pkg::*;

    // Configuration registers. The host must write them only while the block is idle (the
    // block does not enforce this), so the front end folds them into each request's score change.
    logic [7:0]  r_match;
    logic [7:0]  r_ts_pen;
    logic [7:0]  r_tv_pen;
    logic [9:0]  r_drop;
    logic [15:0] r_min_score;
    logic        w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= MATCH_RST;
            r_ts_pen    <= TS_RST;
            r_tv_pen    <= TV_RST;
            r_drop      <= DROP_RST;
            r_min_score <= MIN_RST;
        end else if (w_cfg_write) begin
            case (paddr[4:2])
                REG_MATCH: r_match     <= pwdata[7:0];
                REG_TS:    r_ts_pen    <= pwdata[7:0];
                REG_TV:    r_tv_pen    <= pwdata[7:0];
                REG_DROP:  r_drop      <= pwdata[9:0];
                REG_MIN:   r_min_score <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MATCH: prdata = {24'd0, r_match};
            REG_TS:    prdata = {24'd0, r_ts_pen};
            REG_TV:    prdata = {24'd0, r_tv_pen};
            REG_DROP:  prdata = {22'd0, r_drop};
            REG_MIN:   prdata = {16'd0, r_min_score};
            default:   prdata = 32'd0;
        endcase
    end

    // The front end decodes the action, folds the base comparison and the penalty
    // choice into a signed score change, and pushes the request into the queue.
    // It stalls only when the queue is full. The output register and the report
    // stage together hold two unclaimed results; a further finish then waits at the
    // head of the queue, and the requester is stalled once the queue behind it fills.
    t_cmd  w_front_cmd;
    t_cmd  w_head_cmd;
    logic  w_push;
    logic  w_pop;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_snap_load;
    logic  w_snap_ready;
    t_snap w_snap;

    sxe_front u_front (
        .i_valid        (i_in_valid),
        .i_action       (i_action),
        .i_gen_base     (i_gen_base),
        .i_est_base     (i_est_base),
        .i_gen_position (i_gen_position),
        .i_est_position (i_est_position),
        .i_seed_len     (i_seed_len),
        .i_match        (r_match),
        .i_ts_pen       (r_ts_pen),
        .i_tv_pen       (r_tv_pen),
        .i_q_full       (w_q_full),
        .o_stall        (o_in_stall),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    sxe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // The back end owns the hit state. Rather than a running sum it keeps the
    // deficit of the sum below the best, which keeps the per-pair compare narrow.
    // Only a finish request waits, and only when the report stages are full.
    sxe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_head_cmd),
        .i_empty      (w_q_empty),
        .i_drop       (r_drop),
        .i_snap_ready (w_snap_ready),
        .o_pop        (w_pop),
        .o_snap_load  (w_snap_load),
        .o_snap       (w_snap)
    );

    // The report stage finishes the sums and positions of a hit and holds the
    // result in an output register until the consumer takes it.
    sxe_report u_report (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_snap_load),
        .i_snap        (w_snap),
        .i_min_score   (r_min_score),
        .i_out_stall   (i_out_stall),
        .o_ready       (w_snap_ready),
        .o_valid       (o_out_valid),
        .o_keep        (o_keep),
        .o_gen_start   (o_gen_start),
        .o_est_start   (o_est_start),
        .o_seg_length  (o_seg_length),
        .o_total_score (o_total_score),
        .o_diag_extent (o_diag_extent)
    );

    // A request pushed into the queue is waiting there on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_empty)
        else $error("queue empty right after a push");

    // The back end never takes a request from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_empty |-> !w_pop)
        else $error("pop from an empty queue");

    // A full queue cannot also report empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_q_empty)
        else $error("queue both full and empty");

    // Reset leaves no result pending at the output.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

>>> hw/rtl/sxe_front.sv
module sxe_front (
    input  logic          i_valid,
    input  logic [2:0]    i_action,
    input  logic [7:0]    i_gen_base,
    input  logic [7:0]    i_est_base,
    input  logic [31:0]   i_gen_position,
    input  logic [31:0]   i_est_position,
    input  logic [7:0]    i_seed_len,
    input  logic [7:0]    i_match,
    input  logic [7:0]    i_ts_pen,
    input  logic [7:0]    i_tv_pen,
    input  logic          i_q_full,
    output logic          o_stall,
    output logic          o_push,
    output sxe_pkg::t_cmd o_cmd
);
    import sxe_pkg::*;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        if (c inside {[8'h61:8'h7a]}) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_transition(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] ua;
        logic [7:0] ub;
        ua = up_case(a);
        ub = up_case(b);
        return ((ua == CH_A) && (ub == CH_G)) || ((ua == CH_G) && (ub == CH_A)) ||
               ((ua == CH_C) && (ub == CH_T)) || ((ua == CH_T) && (ub == CH_C));
    endfunction

    logic              w_mismatch;
    logic [7:0]        w_pen;
    logic signed [9:0] w_ext_gain;
    logic signed [9:0] w_seed_gain;
    logic              w_known;

    assign w_mismatch  = (i_gen_base != i_est_base);
    assign w_pen       = is_transition(i_est_base, i_gen_base) ? i_ts_pen : i_tv_pen;
    assign w_ext_gain  = $signed({2'b00, i_match}) -
                         $signed({2'b00, (w_mismatch ? w_pen : 8'd0)});
    assign w_seed_gain = w_mismatch ? 10'sd0 : $signed({2'b00, i_match});

    always_comb begin
        o_cmd          = '0;
        o_cmd.gen_pos  = i_gen_position;
        o_cmd.est_pos  = i_est_position;
        o_cmd.seed_len = i_seed_len;
        o_cmd.zero     = (i_gen_base == 8'd0) || (i_est_base == 8'd0);
        o_cmd.kind     = CMD_START;
        o_cmd.phase    = PH_RIGHT;
        o_cmd.gain     = w_ext_gain;
        w_known        = 1'b1;
        case (i_action)
            ACT_START: begin
                o_cmd.kind = CMD_START;
            end
            ACT_RIGHT: begin
                o_cmd.kind  = CMD_PAIR;
                o_cmd.phase = PH_RIGHT;
            end
            ACT_SEED: begin
                o_cmd.kind  = CMD_PAIR;
                o_cmd.phase = PH_SEED;
                o_cmd.gain  = w_seed_gain;
            end
            ACT_LEFT: begin
                o_cmd.kind  = CMD_PAIR;
                o_cmd.phase = PH_LEFT;
            end
            ACT_FINISH: begin
                o_cmd.kind = CMD_FINISH;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    // Unknown action codes are taken and dropped here.
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && w_known;

endmodule

>>> hw/rtl/sxe_queue.sv
module sxe_queue #(
    parameter int unsigned DEPTH = sxe_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sxe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output sxe_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import sxe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hw/rtl/sxe_back.sv
module sxe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sxe_pkg::t_cmd  i_cmd,
    input  logic           i_empty,
    input  logic [9:0]     i_drop,
    input  logic           i_snap_ready,
    output logic           o_pop,
    output logic           o_snap_load,
    output sxe_pkg::t_snap o_snap
);
    import sxe_pkg::*;

    logic [31:0] r_gen_pos,   n_gen_pos;
    logic [31:0] r_est_pos,   n_est_pos;
    logic [7:0]  r_seed_len,  n_seed_len;
    logic [31:0] r_pairs,     n_pairs;
    logic [10:0] r_deficit,   n_deficit;
    logic [39:0] r_right_best, n_right_best;
    logic [31:0] r_right_cnt, n_right_cnt;
    logic [39:0] r_left_best, n_left_best;
    logic [31:0] r_left_cnt,  n_left_cnt;
    logic [15:0] r_seed_sum,  n_seed_sum;
    logic        r_ext,       n_ext;
    t_phase      r_phase,     n_phase;

    logic               w_is_finish;
    logic               w_older;
    logic               w_enter;
    logic               w_ext_eff;
    logic [31:0]        w_pairs_eff;
    logic [10:0]        w_def_eff;
    logic [31:0]        w_pairs_inc;
    logic signed [11:0] w_diff;
    logic [11:0]        w_rise;
    logic [39:0]        w_best_sel;
    logic [39:0]        w_best_new;
    logic               w_stop;
    logic [16:0]        w_seed_add;

    assign w_is_finish = (i_cmd.kind == CMD_FINISH);
    assign o_pop       = !i_empty && (!w_is_finish || i_snap_ready);
    assign o_snap_load = !i_empty && w_is_finish && i_snap_ready;

    assign w_older     = (i_cmd.phase < r_phase);
    assign w_enter     = (i_cmd.phase > r_phase);
    assign w_ext_eff   = w_enter || r_ext;
    assign w_pairs_eff = w_enter ? 32'd0 : r_pairs;
    assign w_def_eff   = w_enter ? 11'd0 : r_deficit;
    assign w_pairs_inc = w_pairs_eff + 32'd1;

    // The deficit is how far the running sum lies below the best sum.
    // A negative result means the pair lifts the sum past the best.
    assign w_diff     = $signed({1'b0, w_def_eff}) - $signed({{2{i_cmd.gain[9]}}, i_cmd.gain});
    assign w_rise     = 12'(-w_diff);
    assign w_best_sel = (i_cmd.phase == PH_LEFT) ? r_left_best : r_right_best;
    assign w_best_new = w_best_sel + {32'd0, w_rise[7:0]};
    assign w_stop     = (!w_diff[11] && (w_diff[10:0] > {1'b0, i_drop})) ||
                        (w_pairs_inc == 32'hFFFF_FFFF);
    assign w_seed_add = {1'b0, r_seed_sum} + {9'd0, i_cmd.gain[7:0]};

    always_comb begin
        n_gen_pos    = r_gen_pos;
        n_est_pos    = r_est_pos;
        n_seed_len   = r_seed_len;
        n_pairs      = r_pairs;
        n_deficit    = r_deficit;
        n_right_best = r_right_best;
        n_right_cnt  = r_right_cnt;
        n_left_best  = r_left_best;
        n_left_cnt   = r_left_cnt;
        n_seed_sum   = r_seed_sum;
        n_ext        = r_ext;
        n_phase      = r_phase;
        if (o_pop) begin
            case (i_cmd.kind)
                CMD_START: begin
                    n_gen_pos    = i_cmd.gen_pos;
                    n_est_pos    = i_cmd.est_pos;
                    n_seed_len   = i_cmd.seed_len;
                    n_pairs      = '0;
                    n_deficit    = '0;
                    n_right_best = '0;
                    n_right_cnt  = '0;
                    n_left_best  = '0;
                    n_left_cnt   = '0;
                    n_seed_sum   = '0;
                    n_ext        = 1'b1;
                    n_phase      = PH_RIGHT;
                end
                CMD_PAIR: begin
                    if (!w_older) begin
                        if (w_enter) begin
                            n_phase   = i_cmd.phase;
                            n_pairs   = '0;
                            n_deficit = '0;
                            n_ext     = 1'b1;
                        end
                        if (w_ext_eff) begin
                            if (i_cmd.phase == PH_SEED) begin
                                if (w_pairs_eff < {24'd0, r_seed_len}) begin
                                    n_pairs    = w_pairs_inc;
                                    n_seed_sum = w_seed_add[16] ? 16'hFFFF : w_seed_add[15:0];
                                end
                            end else if ((i_cmd.phase == PH_RIGHT) && i_cmd.zero) begin
                                n_ext = 1'b0;
                            end else begin
                                n_pairs = w_pairs_inc;
                                n_ext   = !w_stop;
                                if (w_diff[11]) begin
                                    n_deficit = '0;
                                    if (i_cmd.phase == PH_LEFT) begin
                                        n_left_best = w_best_new;
                                        n_left_cnt  = w_pairs_inc;
                                    end else begin
                                        n_right_best = w_best_new;
                                        n_right_cnt  = w_pairs_inc;
                                    end
                                end else begin
                                    n_deficit = w_diff[10:0];
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_snap.sum_rs    = {1'b0, r_right_best} + {25'd0, r_seed_sum};
        o_snap.left_best = r_left_best;
        o_snap.gen_pos   = r_gen_pos;
        o_snap.est_pos   = r_est_pos;
        o_snap.back_cnt  = {24'd0, r_seed_len} + r_left_cnt;
        o_snap.fwd_cnt   = r_right_cnt + {24'd0, r_seed_len};
        o_snap.right_cnt = r_right_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_pos    <= '0;
            r_est_pos    <= '0;
            r_seed_len   <= '0;
            r_pairs      <= '0;
            r_deficit    <= '0;
            r_right_best <= '0;
            r_right_cnt  <= '0;
            r_left_best  <= '0;
            r_left_cnt   <= '0;
            r_seed_sum   <= '0;
            r_ext        <= 1'b1;
            r_phase      <= PH_RIGHT;
        end else begin
            r_gen_pos    <= n_gen_pos;
            r_est_pos    <= n_est_pos;
            r_seed_len   <= n_seed_len;
            r_pairs      <= n_pairs;
            r_deficit    <= n_deficit;
            r_right_best <= n_right_best;
            r_right_cnt  <= n_right_cnt;
            r_left_best  <= n_left_best;
            r_left_cnt   <= n_left_cnt;
            r_seed_sum   <= n_seed_sum;
            r_ext        <= n_ext;
            r_phase      <= n_phase;
        end
    end

endmodule

>>> hw/rtl/sxe_report.sv
module sxe_report (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  sxe_pkg::t_snap i_snap,
    input  logic [15:0]    i_min_score,
    input  logic           i_out_stall,
    output logic           o_ready,
    output logic           o_valid,
    output logic           o_keep,
    output logic [31:0]    o_gen_start,
    output logic [31:0]    o_est_start,
    output logic [31:0]    o_seg_length,
    output logic [31:0]    o_total_score,
    output logic [31:0]    o_diag_extent
);
    import sxe_pkg::*;

    t_snap       r_snap;
    logic        r_snap_valid, n_snap_valid;
    logic        r_out_valid,  n_out_valid;
    logic        r_keep;
    logic [31:0] r_gen_start;
    logic [31:0] r_est_start;
    logic [31:0] r_seg_length;
    logic [31:0] r_total_score;
    logic [31:0] r_diag_extent;

    logic        w_out_free;
    logic [41:0] w_total;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_ready      = !r_snap_valid || w_out_free;
    assign n_snap_valid = i_load || (r_snap_valid && !w_out_free);
    assign n_out_valid  = w_out_free ? r_snap_valid : r_out_valid;
    assign w_total      = {1'b0, r_snap.sum_rs} + {2'b00, r_snap.left_best};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
        if (w_out_free && r_snap_valid) begin
            r_keep        <= (w_total >= {26'd0, i_min_score});
            r_total_score <= (w_total[41:32] != '0) ? 32'hFFFF_FFFF : w_total[31:0];
            r_gen_start   <= r_snap.gen_pos - r_snap.back_cnt;
            r_est_start   <= r_snap.est_pos - r_snap.back_cnt;
            r_seg_length  <= r_snap.right_cnt + r_snap.back_cnt;
            r_diag_extent <= r_snap.gen_pos + r_snap.fwd_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_snap_valid <= n_snap_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_keep        = r_keep;
    assign o_gen_start   = r_gen_start;
    assign o_est_start   = r_est_start;
    assign o_seg_length  = r_seg_length;
    assign o_total_score = r_total_score;
    assign o_diag_extent = r_diag_extent;

endmodule
